[rtl/b64e_pkg.sv]
// Shared types, constants and the alphabet lookup for the Base64 stream encoder.
// Used by every module under rtl/. Depends on nothing else.
package b64e_pkg;

    // Group queue depth between front and back, and the widths that follow from it.
    localparam int QDepth = 2;
    localparam int QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCw    = $clog2(QDepth + 1);

    localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
    localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'

    // Number of valid bytes in a queued group.
    localparam logic [1:0] NB_ONE   = 2'd1;
    localparam logic [1:0] NB_TWO   = 2'd2;
    localparam logic [1:0] NB_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_group;
        logic       message_done;
    } t_out_item;

    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  nbytes;
        logic        done;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < 6'd26) begin
            c = 8'h41 + {2'b00, idx};
        end else if (idx < 6'd52) begin
            c = 8'h61 + {2'b00, idx - 6'd26};
        end else if (idx < 6'd62) begin
            c = 8'h30 + {2'b00, idx - 6'd52};
        end else if (idx == 6'd62) begin
            c = PLUS_CHAR;
        end else begin
            c = SLASH_CHAR;
        end
        return c;
    endfunction

endpackage

[rtl/base64_stream_encoder.sv]
// Channel   Dir  Handshake                 Payload
// in        in   i_in_valid / o_in_stall   i_in_item  (data_byte, end_of_message)
// out       out  o_out_valid / i_out_stall o_out_item (out_char, last_of_group, message_done)
//
// A byte is taken every cycle while the two-entry group queue has room; the back end
// sends one character per cycle while i_out_stall is low, four characters per group.
// A group passes the queue memory, the group register and the character register.
// Reset (i_rst_n low, synchronous) empties the queue, the fill count and the output.
// An output stall holds the character register; the front keeps taking bytes until
// the queue fills, then raises o_in_stall.
//
// Top level of the Base64 stream encoder: front end, group queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
module base64_stream_encoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  b64e_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output b64e_pkg::t_out_item  o_out_item
);

    logic                 push, pop;
    b64e_pkg::t_group     push_grp, head;
    b64e_pkg::t_q_status  q_status;

    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_status.full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_push_grp (push_grp)
    );

    b64e_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_grp (push_grp),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_empty   (q_status.empty),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    a_q_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("group queue reports full and empty at once");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("front end pushed a group into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("back end popped an empty queue");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.message_done) |-> o_out_item.last_of_group)
        else $error("message end flagged on a character that does not close a group");

endmodule

[rtl/b64e_front.sv]
// Front end: accepts input bytes, holds a partial group and pushes complete
// or flushed groups into the group queue. Depends on b64e_pkg.
module b64e_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  b64e_pkg::t_in_item   i_in_item,
    input  logic                 i_q_full,
    output logic                 o_in_stall,
    output logic                 o_push,
    output b64e_pkg::t_group     o_push_grp
);

    logic [7:0] r_held0, r_held1;
    logic [1:0] r_fill, n_fill;
    logic       accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        o_push     = 1'b0;
        o_push_grp = '0;
        n_fill     = r_fill;
        if (accept) begin
            o_push_grp.done = i_in_item.end_of_message;
            if (r_fill == 2'd2) begin
                o_push            = 1'b1;
                o_push_grp.bits   = {r_held0, r_held1, i_in_item.data_byte};
                o_push_grp.nbytes = b64e_pkg::NB_THREE;
                n_fill            = 2'd0;
            end else if (i_in_item.end_of_message) begin
                o_push = 1'b1;
                n_fill = 2'd0;
                if (r_fill == 2'd1) begin
                    o_push_grp.bits   = {r_held0, i_in_item.data_byte, 8'h00};
                    o_push_grp.nbytes = b64e_pkg::NB_TWO;
                end else begin
                    o_push_grp.bits   = {i_in_item.data_byte, 16'h0000};
                    o_push_grp.nbytes = b64e_pkg::NB_ONE;
                end
            end else begin
                n_fill = r_fill + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_fill == 2'd0) begin
            r_held0 <= i_in_item.data_byte;
        end
        if (accept && r_fill == 2'd1) begin
            r_held1 <= i_in_item.data_byte;
        end
    end

endmodule

[rtl/b64e_queue.sv]
// Small FIFO of byte-group descriptors between front and back end.
// Depends on b64e_pkg for the group type and depth.
module b64e_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64e_pkg::t_group     i_push_grp,
    input  logic                 i_pop,
    output b64e_pkg::t_group     o_head,
    output b64e_pkg::t_q_status  o_status
);

    b64e_pkg::t_group          r_mem [b64e_pkg::QDepth];
    logic [b64e_pkg::QAw-1:0]  r_wr_ptr, r_rd_ptr;
    logic [b64e_pkg::QCw-1:0]  r_count;

    function automatic logic [b64e_pkg::QAw-1:0] ptr_inc(input logic [b64e_pkg::QAw-1:0] p);
        logic [b64e_pkg::QAw-1:0] r;
        if (p == b64e_pkg::QAw'(b64e_pkg::QDepth - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign o_status.full  = (r_count == b64e_pkg::QCw'(b64e_pkg::QDepth));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_grp;
        end
    end

endmodule

[rtl/b64e_back.sv]
// Back end: takes one group at a time from the queue and sends its four characters,
// one per cycle unless the output stalls, through an output register. Depends on b64e_pkg.
module b64e_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  b64e_pkg::t_group     i_head,
    input  logic                 i_q_empty,
    output logic                 o_pop,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output b64e_pkg::t_out_item  o_out_item
);

    b64e_pkg::t_group     r_grp;
    logic                 r_busy;
    logic [1:0]           r_idx;
    logic                 r_out_valid;
    b64e_pkg::t_out_item  r_out, n_out;
    logic                 load;
    logic [5:0]           sextet;

    assign load  = !r_out_valid || !i_out_stall;
    // A new group may enter in the same cycle the last character of the current one leaves.
    assign o_pop = !i_q_empty && (!r_busy || (load && r_idx == 2'd3));

    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_grp.bits[23:18];
            2'd1:    sextet = r_grp.bits[17:12];
            2'd2:    sextet = r_grp.bits[11:6];
            default: sextet = r_grp.bits[5:0];
        endcase
        n_out.out_char      = b64e_pkg::b64_char(sextet);
        if ((r_grp.nbytes == b64e_pkg::NB_ONE && r_idx >= 2'd2) ||
            (r_grp.nbytes == b64e_pkg::NB_TWO && r_idx == 2'd3)) begin
            n_out.out_char = b64e_pkg::PAD_CHAR;
        end
        n_out.last_of_group = (r_idx == 2'd3);
        n_out.message_done  = (r_idx == 2'd3) && r_grp.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (load && r_busy) begin
                r_idx <= r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && r_busy) begin
            r_out <= n_out;
        end
        if (o_pop) begin
            r_grp <= i_head;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
